@@ hdl/range_match_counter_unit_assert.svh @@
// Assertion macros shared by the range match counter RTL.
`ifndef RANGE_MATCH_COUNTER_UNIT_ASSERT_SVH
`define RANGE_MATCH_COUNTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define RMC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rmc assertion failed");

// Next-cycle implication, disabled while in reset.
`define RMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rmc assertion failed");

`endif

@@ hdl/rmc_pkg.sv @@
package rmc_pkg;

	localparam int MAX_RANGES = 64;
	localparam int ID_W       = 64;
	localparam int COUNT_W    = 32;
	localparam int S_TDATA_W  = 3 * ID_W;
	localparam int M_TDATA_W  = ((COUNT_W + 2 + 7) / 8) * 8;

	localparam logic [COUNT_W-1:0] HIT_MAX = {COUNT_W{1'b1}};

	typedef enum logic [0:0] {
		OP_INSERT = 1'b0,
		OP_QUERY  = 1'b1
	} op_t;

	// One item as it travels down the chain. A query carries its id in key.
	typedef struct packed {
		op_t             opcode;
		logic [ID_W-1:0] key;
		logic [ID_W-1:0] high;
		logic            hit;
		logic            placed;
	} item_t;

endpackage

@@ hdl/rmc_cell.sv @@
module rmc_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  logic          in_valid,
	input  rmc_pkg::item_t in_item,
	output logic          out_valid,
	output rmc_pkg::item_t out_item,
	output logic          occupied
);

	logic                     valid_q;
	logic [rmc_pkg::ID_W-1:0] start_q;
	logic [rmc_pkg::ID_W-1:0] end_q;
	logic                     out_valid_q;
	rmc_pkg::item_t           out_item_q;
	rmc_pkg::item_t           next_item;
	logic                     claim;
	logic                     match;

	// The first empty cell an insert reaches takes its range.
	assign claim = in_valid && (in_item.opcode == rmc_pkg::OP_INSERT)
		&& !in_item.placed && !valid_q;

	assign match = valid_q && (in_item.opcode == rmc_pkg::OP_QUERY)
		&& (start_q <= in_item.key) && (in_item.key <= end_q);

	always_comb begin
		next_item        = in_item;
		next_item.hit    = in_item.hit | match;
		next_item.placed = in_item.placed | claim;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= in_valid;
			if (claim) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_item_q <= next_item;
			if (claim) begin
				start_q <= in_item.key;
				end_q   <= in_item.high;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
	assign occupied  = valid_q;

endmodule

@@ hdl/rmc_tally.sv @@
module rmc_tally (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             advance,
	input  logic                             in_valid,
	input  rmc_pkg::item_t                   in_item,
	output logic                             out_valid,
	output logic                             is_inside,
	output logic [rmc_pkg::COUNT_W-1:0]      match_total,
	output logic                             table_full
);

	logic                        out_valid_q;
	logic [rmc_pkg::COUNT_W-1:0] hit_q;
	logic                        inside_q;
	logic                        full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			hit_q       <= '0;
		end else if (advance) begin
			out_valid_q <= in_valid;
			// saturate at the top of the range
			if (in_valid && in_item.hit && (hit_q != rmc_pkg::HIT_MAX)) begin
				hit_q <= hit_q + {{(rmc_pkg::COUNT_W-1){1'b0}}, 1'b1};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			inside_q <= in_item.hit;
			// an insert that left the chain unplaced was dropped
			full_q   <= (in_item.opcode == rmc_pkg::OP_INSERT) && !in_item.placed;
		end
	end

	assign out_valid   = out_valid_q;
	assign is_inside   = inside_q;
	assign match_total = hit_q;
	assign table_full  = full_q;

endmodule

@@ hdl/range_match_counter_unit.sv @@
// Range match counter: a chain of MAX_RANGES cells, one stored range per cell.
// An item passes through every cell register in turn and then the tally register before the output is valid.
// Throughput: one item per cycle while the output is not stalled; each item steps one cell per advancing cycle.
// A stalled output freezes the whole chain until the item is taken.
// Reset (arst_n low) empties every cell and clears the match count.
`include "range_match_counter_unit_assert.svh"

module range_match_counter_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// range_low [63:0], range_high [127:64], query_id [191:128]
	input  logic [rmc_pkg::S_TDATA_W-1:0]     s_tdata,
	// opcode [0]
	input  logic [0:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// is_inside [0], match_total [32:1], table_full [33], zero [39:34]
	output logic [rmc_pkg::M_TDATA_W-1:0]     m_tdata
);

	localparam int N = rmc_pkg::MAX_RANGES;
	localparam int W = rmc_pkg::ID_W;

	logic                        advance;
	logic [N:0]                  chain_valid;
	rmc_pkg::item_t              chain_item [N+1];
	logic [N-1:0]                occ;
	logic                        is_inside;
	logic                        table_full;
	logic [rmc_pkg::COUNT_W-1:0] match_total;

	// hold everything while the output item waits
	assign advance  = !m_tvalid || m_tready;
	assign s_tready = advance;

	always_comb begin
		chain_valid[0]         = s_tvalid;
		chain_item[0].opcode   = rmc_pkg::op_t'(s_tuser);
		chain_item[0].key      = (rmc_pkg::op_t'(s_tuser) == rmc_pkg::OP_QUERY)
			? s_tdata[3*W-1:2*W] : s_tdata[W-1:0];
		chain_item[0].high     = s_tdata[2*W-1:W];
		chain_item[0].hit      = 1'b0;
		chain_item[0].placed   = 1'b0;
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		rmc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.advance   (advance),
			.in_valid  (chain_valid[i]),
			.in_item   (chain_item[i]),
			.out_valid (chain_valid[i+1]),
			.out_item  (chain_item[i+1]),
			.occupied  (occ[i])
		);
	end

	rmc_tally u_tally (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.in_valid    (chain_valid[N]),
		.in_item     (chain_item[N]),
		.out_valid   (m_tvalid),
		.is_inside   (is_inside),
		.match_total (match_total),
		.table_full  (table_full)
	);

	assign m_tdata = {{(rmc_pkg::M_TDATA_W-rmc_pkg::COUNT_W-2){1'b0}},
		table_full, match_total, is_inside};

	// cells fill strictly from the head of the chain
	`RMC_ASSERT_NOW(a_occ_prefix, clk, arst_n, 1'b1,
		((occ + {{(N-1){1'b0}}, 1'b1}) & occ) == '0)
	`RMC_ASSERT_NEXT(a_count_monotone, clk, arst_n, 1'b1,
		match_total >= $past(match_total))
	`RMC_ASSERT_NOW(a_placed_is_insert, clk, arst_n, chain_valid[N] && chain_item[N].placed,
		chain_item[N].opcode == rmc_pkg::OP_INSERT)
	`RMC_ASSERT_NOW(a_flags_exclusive, clk, arst_n, m_tvalid, !(is_inside && table_full))

endmodule

@@ tb/range_match_counter_checker.sv @@
`timescale 1ns / 100ps

module range_match_counter_checker
	import rmc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic [0:0]           s_tuser,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_TDATA_W-1:0] m_tdata,
	output int                   errors,
	output int                   outstanding,
	output int                   hit_results,
	output int                   dropped_results
);

	typedef struct packed {
		logic               in_range;
		logic [COUNT_W-1:0] total;
		logic               full;
	} lookup_result_t;

	localparam int REPORT_CAP = 20;

	lookup_result_t  pending_lookups[$];
	logic [ID_W-1:0] span_start [MAX_RANGES];
	logic [ID_W-1:0] span_end   [MAX_RANGES];
	int unsigned     span_count;
	logic [COUNT_W-1:0] match_count;

	// Update the table and hit count for one item and return what the block should report.
	function automatic lookup_result_t classify_item(op_t op, logic [ID_W-1:0] lo,
			logic [ID_W-1:0] hi, logic [ID_W-1:0] id);
		lookup_result_t r;
		logic found;
		r = '0;
		found = 1'b0;
		if (op == OP_INSERT) begin
			if (span_count < MAX_RANGES) begin
				span_start[span_count] = lo;
				span_end[span_count] = hi;
				span_count++;
			end else begin
				r.full = 1'b1;
			end
		end else begin
			for (int k = 0; k < span_count; k++)
				if (id >= span_start[k] && id <= span_end[k])
					found = 1'b1;
			if (found) begin
				r.in_range = 1'b1;
				if (match_count != HIT_MAX)
					match_count++;
			end
		end
		r.total = match_count;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		lookup_result_t want;
		lookup_result_t got;
		if (!arst_n) begin
			pending_lookups.delete();
			span_count = 0;
			match_count = '0;
			errors = 0;
			outstanding = 0;
			hit_results = 0;
			dropped_results = 0;
		end else begin
			// retire the output item first: it always belongs to an earlier input
			if (m_tvalid && m_tready) begin
				got.in_range = m_tdata[0];
				got.total = m_tdata[COUNT_W:1];
				got.full = m_tdata[COUNT_W+1];
				if (pending_lookups.size() == 0) begin
					if (errors < REPORT_CAP)
						$display("%0t: result with nothing pending: %h", $time, got);
					errors++;
				end else begin
					want = pending_lookups.pop_front();
					if (got.in_range !== want.in_range) begin
						if (errors < REPORT_CAP)
							$display("%0t: is_inside expected %0b got %0b",
								$time, want.in_range, got.in_range);
						errors++;
					end
					if (got.total !== want.total) begin
						if (errors < REPORT_CAP)
							$display("%0t: match_total expected %0d got %0d",
								$time, want.total, got.total);
						errors++;
					end
					if (got.full !== want.full) begin
						if (errors < REPORT_CAP)
							$display("%0t: table_full expected %0b got %0b",
								$time, want.full, got.full);
						errors++;
					end
					if (want.in_range)
						hit_results++;
					if (want.full)
						dropped_results++;
				end
			end
			if (s_tvalid && s_tready)
				pending_lookups.push_back(classify_item(op_t'(s_tuser[0]),
					s_tdata[ID_W-1:0], s_tdata[2*ID_W-1:ID_W], s_tdata[3*ID_W-1:2*ID_W]));
			outstanding = pending_lookups.size();
		end
	end

endmodule

@@ tb/range_match_counter_unit_tb.sv @@
`timescale 1ns / 100ps

module range_match_counter_unit_tb;
	import rmc_pkg::*;

	localparam int RANDOM_ITEMS = 520;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 2 * MAX_RANGES + 20;
	localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [0:0]           s_tuser = OP_INSERT;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	int errors;
	int outstanding;
	int hit_results;
	int dropped_results;

	bit hold_req = 1'b0;
	bit steady = 1'b0;
	int inserts_sent = 0;
	int queries_sent = 0;
	logic [ID_W-1:0] sent_lo[$];
	logic [ID_W-1:0] sent_hi[$];

	range_match_counter_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	range_match_counter_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.errors          (errors),
		.outstanding     (outstanding),
		.hit_results     (hit_results),
		.dropped_results (dropped_results)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic logic [ID_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Mostly no gap or a short one, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 60);
	endfunction

	task automatic send_item(op_t op, logic [ID_W-1:0] lo, logic [ID_W-1:0] hi,
			logic [ID_W-1:0] id);
		int gap;
		gap = gap_len();
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {id, hi, lo};
		s_tuser <= op;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (op == OP_INSERT) begin
			inserts_sent++;
			sent_lo.push_back(lo);
			sent_hi.push_back(hi);
		end else begin
			queries_sent++;
		end
	endtask

	// Fill the unused field with noise.
	task automatic insert_range(logic [ID_W-1:0] lo, logic [ID_W-1:0] hi);
		send_item(OP_INSERT, lo, hi, rand64());
	endtask

	task automatic query_at(logic [ID_W-1:0] id);
		send_item(OP_QUERY, rand64(), rand64(), id);
	endtask

	// Aim queries at the edges and midpoints of ranges already sent, at the ends of the id space, or at random ids.
	function automatic logic [ID_W-1:0] pick_query_id();
		int k;
		if (sent_lo.size() == 0)
			return rand64();
		k = $urandom_range(0, sent_lo.size() - 1);
		case ($urandom_range(0, 9))
			0: return sent_lo[k] - 1;
			1: return sent_lo[k];
			2: return sent_hi[k];
			3: return sent_hi[k] + 1;
			4: return sent_lo[k] + ((sent_hi[k] - sent_lo[k]) >> 1);
			5: return ($urandom_range(0, 1) != 0) ? ID_MAX : '0;
			default: return rand64();
		endcase
	endfunction

	task automatic random_insert();
		logic [ID_W-1:0] a;
		a = rand64();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: insert_range(a, a + $urandom_range(0, 1000));
			4: insert_range(a, a);
			5: insert_range(a, a - $urandom_range(1, 1000));
			default: insert_range(a, rand64());
		endcase
	endtask

	// Receiver: random ready runs and stalls, always ready in steady mode, a long hold-off on request.
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				repeat (LONG_HOLD) begin
					@(negedge clk);
					m_tready <= 1'b0;
				end
			end else if (steady) begin
				@(negedge clk);
				m_tready <= 1'b1;
			end else begin
				repeat ($urandom_range(1, 16)) begin
					@(negedge clk);
					m_tready <= 1'b1;
				end
				repeat (gap_len()) begin
					@(negedge clk);
					m_tready <= 1'b0;
				end
			end
		end
	end

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// empty table, then boundary ranges including a reversed one
		query_at('0);
		query_at(ID_MAX);
		insert_range('0, '0);
		insert_range(ID_MAX, ID_MAX);
		insert_range(64'd1000, 64'd500);
		insert_range(64'h1000, 64'h1fff);
		query_at('0);
		query_at(64'd1);
		query_at(ID_MAX);
		query_at(ID_MAX - 1);
		query_at(64'd750);
		query_at(64'd500);
		query_at(64'd1000);
		query_at(64'h0fff);
		query_at(64'h1000);
		query_at(64'h1fff);
		query_at(64'h2000);
		insert_range(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
		query_at(64'h5555_5555_5555_5555);
		query_at(64'haaaa_aaaa_aaaa_aaab);
		query_at(64'h8000_0000_0000_0000);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 150) begin
				hold_req = 1'b1;
				steady = 1'b1;
			end
			if (i == 240)
				steady = 1'b0;
			if (i == 300) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				wait (outstanding == 0);
			end
			if (i == 360)
				steady = 1'b1;
			if (i == 420)
				steady = 1'b0;
			if ($urandom_range(0, 99) < 30)
				random_insert();
			else
				query_at(pick_query_id());
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d inserts (%0d dropped on a full table) and %0d queries (%0d hits).",
			inserts_sent, dropped_results, queries_sent, hit_results);
		$display("Mismatches seen: %0d, results still pending: %0d.", errors, outstanding);
		if (errors == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
